FILE: design/aoc_pkg.sv
// Shared types and constants for the alpha-over compositing block.
package aoc_pkg;

  localparam logic [7:0] CHAN_MAX   = 8'd255;
  localparam int         QDEPTH     = 4;
  localparam int         QAW        = $clog2(QDEPTH);
  localparam int         QBITS      = 8;   // quotient bits, results never exceed 255
  localparam int         NUM_W      = 24;  // 255*255*255 fits in 24 bits
  localparam int         DEN_W      = 16;
  localparam int         LANES      = 4;   // red, green, blue, alpha
  localparam int         ALPHA_LANE = 3;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic                  partial;
    pix_out_t              byp;
    logic [2:0][7:0]       sc;
    logic [2:0][7:0]       dc;
    logic [7:0]            sa;
    logic [7:0]            da;
    logic [DEN_W-1:0]      den;
  } item_t;

endpackage

FILE: design/aoc_front.sv
// Front end: accepts pixels, classifies by source alpha, forms the common denominator.
module aoc_front import aoc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  pix_in_t pixel,
  output logic    q_push,
  input  logic    q_full,
  output item_t   q_item
);

  logic    fv;
  item_t   item;
  item_t   item_next;
  logic [7:0] inv;

  assign full   = fv & q_full;
  assign q_push = fv & ~q_full;
  assign q_item = item;

  always_comb begin
    inv = CHAN_MAX - pixel.src_alpha;
    item_next.sc  = {pixel.src_blue, pixel.src_green, pixel.src_red};
    item_next.dc  = {pixel.dst_blue, pixel.dst_green, pixel.dst_red};
    item_next.sa  = pixel.src_alpha;
    item_next.da  = pixel.dst_alpha;
    item_next.den = ({pixel.src_alpha, 8'd0} - {8'd0, pixel.src_alpha})
                  + (pixel.dst_alpha * inv);
    item_next.partial = (pixel.src_alpha != CHAN_MAX) && (pixel.src_alpha != 8'd0);
    if (pixel.src_alpha == CHAN_MAX) begin
      item_next.byp = '{pixel.src_red, pixel.src_green, pixel.src_blue, CHAN_MAX};
    end else begin
      item_next.byp = '{pixel.dst_red, pixel.dst_green, pixel.dst_blue, pixel.dst_alpha};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!full) begin
      fv <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full) begin
      item <= item_next;
    end
  end

endmodule

FILE: design/aoc_queue.sv
// Short FIFO decoupling the front end from the arithmetic back end.
module aoc_queue import aoc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  output logic  q_full,
  input  logic  rd,
  output logic  q_empty,
  output item_t rdata
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

FILE: design/aoc_back.sv
// Back end: products, numerators, a bit-per-stage restoring divider for the color lanes.
module aoc_back import aoc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  output logic     q_pop,
  input  item_t    q_item,
  output logic     empty,
  input  logic     pop,
  output pix_out_t result
);

  typedef struct packed {
    logic             partial;
    pix_out_t         byp;
    logic [7:0]       inv;
    logic [DEN_W-1:0] den;
    logic [2:0][15:0] ps;
    logic [2:0][15:0] pd;
  } prod_t;

  typedef struct packed {
    logic                        partial;
    pix_out_t                    byp;
    logic [DEN_W-1:0]            den;
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QBITS-1:0] q;
  } div_t;

  logic  pv;
  prod_t pr;
  prod_t pr_next;
  logic  dv [QBITS+1];
  div_t  ds [QBITS+1];   // index 0 holds numerators, 1..QBITS the divider stages
  div_t  ds_next [QBITS+1];
  logic  out_valid;
  logic  adv;

  assign adv     = !dv[QBITS] || !out_valid || pop;
  assign q_pop   = adv && !q_empty;
  assign empty   = !out_valid;

  always_comb begin
    pr_next.partial = q_item.partial;
    pr_next.byp     = q_item.byp;
    pr_next.inv     = CHAN_MAX - q_item.sa;
    pr_next.den     = q_item.den;
    for (int c = 0; c < 3; c++) begin
      pr_next.ps[c] = q_item.sc[c] * q_item.sa;
      pr_next.pd[c] = q_item.dc[c] * q_item.da;
    end
  end

  always_comb begin
    logic [NUM_W-1:0] dshift;
    logic [DEN_W:0]   asum;
    ds_next[0].partial = pr.partial;
    ds_next[0].byp     = pr.byp;
    ds_next[0].den     = pr.den;
    ds_next[0].q       = '0;
    for (int c = 0; c < 3; c++) begin
      ds_next[0].rem[c] = ({pr.ps[c], 8'd0} - {8'd0, pr.ps[c]})
                        + NUM_W'(pr.pd[c] * pr.inv);
    end
    // alpha = den / 255 as (den + 1 + den/256) / 256, exact for den below 65536
    asum = (DEN_W+1)'(pr.den) + (DEN_W+1)'(pr.den >> 8) + 1'b1;
    ds_next[0].rem[ALPHA_LANE] = '0;
    ds_next[0].q[ALPHA_LANE]   = asum[DEN_W-1:QBITS];
    for (int s = 1; s <= QBITS; s++) begin
      ds_next[s] = ds[s-1];
      for (int l = 0; l < ALPHA_LANE; l++) begin
        dshift = NUM_W'(ds[s-1].den) << (QBITS - s);
        if (ds[s-1].rem[l] >= dshift) begin
          ds_next[s].rem[l]           = ds[s-1].rem[l] - dshift;
          ds_next[s].q[l][QBITS - s]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s <= QBITS; s++) dv[s] <= 1'b0;
    end else begin
      if (adv) begin
        pv    <= !q_empty;
        dv[0] <= pv;
        for (int s = 1; s <= QBITS; s++) dv[s] <= dv[s-1];
      end
      if (!out_valid || pop) begin
        out_valid <= dv[QBITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr <= pr_next;
      for (int s = 0; s <= QBITS; s++) ds[s] <= ds_next[s];
    end
    if (!out_valid || pop) begin
      if (ds[QBITS].partial) begin
        result <= '{ds[QBITS].q[0], ds[QBITS].q[1], ds[QBITS].q[2],
                    ds[QBITS].q[ALPHA_LANE]};
      end else begin
        result <= ds[QBITS].byp;
      end
    end
  end

endmodule

FILE: design/alpha_over_composite_unit.sv
// Top level of the straight-alpha source-over compositing block.
//
// Input channel: push/full queue interface carrying one source and one
// destination RGBA pixel per transaction (pixel). A transaction is taken
// when push is high and full is low.
// Result channel: empty/pop queue interface. The oldest result sits on
// result while empty is low and leaves when pop is high.
// Throughput: one pixel per clock, sustained, in both directions, while pop is not withheld.
// Path: when nothing stalls, a pixel passes through one front register,
// the decoupling queue, a product stage, a numerator stage, eight
// restoring divider stages (one quotient bit each) and the output register.
// The eight-stage divider makes up most of the latency.
// When pop is withheld the back pipeline holds, the 4-entry queue fills,
// then the front register holds and full rises.
// Reset (rst, synchronous) empties every stage and the queue; no results
// are pending afterwards.
module alpha_over_composite_unit import aoc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  pix_in_t  pixel,
  output logic     empty,
  input  logic     pop,
  output pix_out_t result
);

  logic  q_wr;
  logic  q_full;
  logic  q_rd;
  logic  q_empty;
  item_t q_wdata;
  item_t q_rdata;

  aoc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_push (q_wr),
    .q_full (q_full),
    .q_item (q_wdata)
  );

  aoc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_empty (q_empty),
    .rdata   (q_rdata)
  );

  aoc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_rd),
    .q_item  (q_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
